FILE: hdl/sdwp_pkg.sv
// Shared types and constants for the second-difference window peak detector.
// No dependencies; imported by every module of the block.
package sdwp_pkg;

  localparam int DEF_INDEX_BITS  = 24;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int WL_BITS  = 12;
  localparam int OFF_BITS = 6;

  localparam logic [WL_BITS-1:0]  WL_RESET  = 12'd175;
  localparam logic [OFF_BITS-1:0] OFF_RESET = 6'd5;

  // register index as decoded from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_INDEX_OFFSET  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: hdl/sdwp_front.sv
// Front end: takes samples, forms the second difference and tracks the window maximum.
// Emits one peak record per closing window with a positive maximum. Uses sdwp_pkg.
module sdwp_front #(
  parameter int INDEX_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [sdwp_pkg::WL_BITS-1:0]      window_length,
  output logic                              push,
  output logic [INDEX_BITS-1:0]             push_index,
  output logic [SAMPLE_BITS+1:0]            push_value
);
  import sdwp_pkg::*;

  localparam int DB = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] older_sample;
  logic signed [SAMPLE_BITS-1:0] newer_sample;
  logic [1:0]                    warmup_count;
  logic [INDEX_BITS-1:0]         diff_index;
  logic [WL_BITS-1:0]            window_position;
  logic signed [DB-1:0]          best_value;
  logic [INDEX_BITS-1:0]         best_index;
  logic                          best_found;

  logic signed [DB-1:0] d;
  logic [WL_BITS:0]     wl_m2;
  logic [WL_BITS:0]     pos_inc;
  logic                 in_win;
  logic                 last_slot;
  logic                 take;
  logic signed [DB-1:0] cand_value;
  logic [INDEX_BITS-1:0] cand_index;
  logic                 warm;

  always_comb begin
    d = DB'(sample) - (DB'(newer_sample) <<< 1) + DB'(older_sample);
    wl_m2 = {1'b0, window_length} - (WL_BITS+1)'(2);
    pos_inc = {1'b0, window_position} + (WL_BITS+1)'(1);
    in_win = (window_length >= WL_BITS'(2)) && ({1'b0, window_position} <= wl_m2);
    last_slot = ({1'b0, window_position} == wl_m2);
    take = !best_found || (d > best_value);
    cand_value = take ? d : best_value;
    cand_index = take ? diff_index : best_index;
    warm = (warmup_count == 2'd2);
  end

  assign push       = accept && warm && in_win && last_slot && (cand_value > 0);
  assign push_index = cand_index;
  assign push_value = cand_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample    <= '0;
      newer_sample    <= '0;
      warmup_count    <= '0;
      diff_index      <= '0;
      window_position <= '0;
      best_value      <= '0;
      best_index      <= '0;
      best_found      <= 1'b0;
    end else if (accept) begin
      older_sample <= newer_sample;
      newer_sample <= sample;
      if (!warm) begin
        warmup_count <= warmup_count + 2'd1;
      end else begin
        if (diff_index != {INDEX_BITS{1'b1}}) begin
          diff_index <= diff_index + INDEX_BITS'(1);
        end
        if (in_win && !last_slot) begin
          best_value <= cand_value;
          best_index <= cand_index;
          best_found <= 1'b1;
        end else begin
          best_value <= '0;
          best_index <= '0;
          best_found <= 1'b0;
        end
        if (pos_inc >= {1'b0, window_length}) begin
          window_position <= '0;
        end else begin
          window_position <= pos_inc[WL_BITS-1:0];
        end
      end
    end
  end

endmodule

FILE: hdl/sdwp_queue.sv
// Short queue of peak records between front and back end.
// Register-based ring with a fill count. Uses sdwp_pkg.
module sdwp_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [WIDTH-1:0]          push_data,
  input  logic                      pop,
  output logic [WIDTH-1:0]          pop_data,
  output sdwp_pkg::queue_stat_t     stat
);
  import sdwp_pkg::*;

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PB-1:0]    wr_ptr;
  logic [PB-1:0]    rd_ptr;
  logic [CB-1:0]    count;

  assign stat.full  = (count == CB'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + PB'(1);
      end
      if (push && !pop) begin
        count <= count + CB'(1);
      end else if (pop && !push) begin
        count <= count - CB'(1);
      end
    end
  end

endmodule

FILE: hdl/sdwp_back.sv
// Back end: pops peak records, applies the index offset and holds the output item.
// Drives the master-side stream. Uses sdwp_pkg.
module sdwp_back #(
  parameter int INDEX_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdwp_pkg::queue_stat_t         stat,
  input  logic [INDEX_BITS-1:0]         rec_index,
  input  logic [SAMPLE_BITS+1:0]        rec_value,
  input  logic [sdwp_pkg::OFF_BITS-1:0] index_offset,
  output logic                          pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [INDEX_BITS:0]           peak_index,
  output logic [SAMPLE_BITS+1:0]        peak_strength
);
  import sdwp_pkg::*;

  assign pop = !stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      peak_index    <= {1'b0, rec_index} - (INDEX_BITS+1)'(index_offset);
      peak_strength <= rec_value;
    end
  end

endmodule

FILE: hdl/ecg_second_diff_window_peak_core.sv
// A result item is registered in the peak queue and then in the back-end output register before it is offered.
// Throughput: one sample per cycle; the front end stalls only when the four-entry
// peak queue is full, which takes a stalled output and several closing windows.
// Reset (synchronous, rst high) clears the history, counters, window maximum and queue,
// and loads window_length 175 and index_offset 5. Uses sdwp_pkg, sdwp_front,
// sdwp_queue and sdwp_back.
module ecg_second_diff_window_peak_core #(
  parameter int INDEX_BITS  = sdwp_pkg::DEF_INDEX_BITS,
  parameter int SAMPLE_BITS = sdwp_pkg::DEF_SAMPLE_BITS,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((INDEX_BITS + SAMPLE_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sample
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // peak_index, peak_strength
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sdwp_pkg::*;

  localparam int REC_W = INDEX_BITS + SAMPLE_BITS + 2;

  logic [WL_BITS-1:0]     window_length;
  logic [OFF_BITS-1:0]    index_offset;
  logic                   accept;
  logic                   push;
  logic                   pop;
  logic [INDEX_BITS-1:0]  push_index;
  logic [SAMPLE_BITS+1:0] push_value;
  logic [REC_W-1:0]       rec;
  queue_stat_t            stat;
  logic [INDEX_BITS:0]    peak_index;
  logic [SAMPLE_BITS+1:0] peak_strength;

  assign pready   = 1'b1;
  assign s_tready = !stat.full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = OUT_W'({peak_strength, peak_index});

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      index_offset  <= OFF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: window_length <= pwdata[WL_BITS-1:0];
        REG_INDEX_OFFSET:  index_offset  <= pwdata[OFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = 32'(window_length);
      REG_INDEX_OFFSET:  prdata = 32'(index_offset);
      default:           prdata = '0;
    endcase
  end

  sdwp_front #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (s_tdata[SAMPLE_BITS-1:0]),
    .window_length (window_length),
    .push          (push),
    .push_index    (push_index),
    .push_value    (push_value)
  );

  sdwp_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_value, push_index}),
    .pop       (pop),
    .pop_data  (rec),
    .stat      (stat)
  );

  sdwp_back #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .stat          (stat),
    .rec_index     (rec[INDEX_BITS-1:0]),
    .rec_value     (rec[REC_W-1:INDEX_BITS]),
    .index_offset  (index_offset),
    .pop           (pop),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .peak_index    (peak_index),
    .peak_strength (peak_strength)
  );

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (s_tvalid && s_tready))
    else $error("peak record pushed without an accepted item");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("peak queue popped while empty");

  a_strength_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (peak_strength != '0) && !peak_strength[SAMPLE_BITS+1])
    else $error("peak item offered with non-positive strength");

endmodule
